>>> design/imucf_pkg.sv
// Shared types, constants and functions of the IMU complementary filter.
`default_nettype none
package imucf_pkg;

	localparam int IN_W   = 24;
	localparam int ANG_W  = 32;
	localparam int CFG_W  = 31;
	localparam int WT_W   = 17;
	localparam int SAT_W  = 72;
	localparam int CXY_W  = 44;
	localparam int CZ_W   = 34;
	localparam int MA_W   = 34;
	localparam int MB_W   = 33;
	localparam int PROD_W = MA_W + MB_W;
	localparam int MAX_ITERS = 24;

	localparam logic [2:0] REG_WINDOW_LOW    = 3'd0;
	localparam logic [2:0] REG_WINDOW_HIGH   = 3'd1;
	localparam logic [2:0] REG_KEEP_WEIGHT   = 3'd2;
	localparam logic [2:0] REG_ACCEL_WEIGHT  = 3'd3;
	localparam logic [2:0] REG_RATE_DIVISOR  = 3'd4;
	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd5;
	localparam logic [2:0] REG_DEG_PER_RAD   = 3'd6;

	localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DIV_INIT,
		CMD_DIV_STEP,
		CMD_MUL_RATE,
		CMD_INTEGRATE,
		CMD_COR_INIT,
		CMD_COR_STEP,
		CMD_MUL_DEG,
		CMD_MUL_KEEP,
		CMD_MUL_ACC,
		CMD_BLEND,
		CMD_EMIT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic    axis;   // 0 pitch, 1 roll
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic cor_done;
		logic in_window;
		logic out_busy;
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_INIT,
		ST_DIV,
		ST_MUL_RATE,
		ST_INTEGRATE,
		ST_COR_INIT,
		ST_COR,
		ST_MUL_DEG,
		ST_MUL_KEEP,
		ST_MUL_ACC,
		ST_BLEND,
		ST_EMIT
	} state_t;

	function automatic logic signed [CZ_W-1:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 34'sd843314857;
			5'd1:  atan_q30 = 34'sd497837830;
			5'd2:  atan_q30 = 34'sd263043837;
			5'd3:  atan_q30 = 34'sd133525159;
			5'd4:  atan_q30 = 34'sd67021687;
			5'd5:  atan_q30 = 34'sd33543516;
			5'd6:  atan_q30 = 34'sd16775851;
			5'd7:  atan_q30 = 34'sd8388438;
			5'd8:  atan_q30 = 34'sd4194284;
			5'd9:  atan_q30 = 34'sd2097149;
			5'd10: atan_q30 = 34'sd1048576;
			5'd11: atan_q30 = 34'sd524288;
			5'd12: atan_q30 = 34'sd262144;
			5'd13: atan_q30 = 34'sd131072;
			5'd14: atan_q30 = 34'sd65536;
			5'd15: atan_q30 = 34'sd32768;
			5'd16: atan_q30 = 34'sd16384;
			5'd17: atan_q30 = 34'sd8192;
			5'd18: atan_q30 = 34'sd4096;
			5'd19: atan_q30 = 34'sd2048;
			5'd20: atan_q30 = 34'sd1024;
			5'd21: atan_q30 = 34'sd512;
			5'd22: atan_q30 = 34'sd256;
			5'd23: atan_q30 = 34'sd128;
			default: atan_q30 = '0;
		endcase
	endfunction

	function automatic logic signed [ANG_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		if (v > SAT_W'(64'sd2147483647))
			sat32 = 32'sh7FFFFFFF;
		else if (v < -SAT_W'(64'sd2147483648))
			sat32 = 32'sh80000000;
		else
			sat32 = v[ANG_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> design/imu_complementary_filter_top.sv
// Top level of the IMU complementary filter (pitch and roll).
// Per axis (pitch, then roll): restoring divide of the rate, multiply, integrate; for a
// sample inside the accel window, per axis a CORDIC, three multiplies and a blend follow.
// One sample at a time; the restoring divider (one bit a cycle) and the CORDIC
// (one iteration a cycle) dominate the latency. A result may wait in the output register.
// Reset (arst_n low, asynchronous): angles zero, registers to their defaults.
`default_nettype none
module imu_complementary_filter_top #(
	parameter int FRAC_BITS  = 16,
	parameter int ATAN_STEPS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [30:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [119:0] s_tdata,  // accel_x, accel_y, accel_z, rate_x, rate_y
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [63:0]       m_tdata   // pitch_angle, roll_angle
);

	imucf_pkg::cmd_t    cmd;
	imucf_pkg::status_t status;

	imucf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	imucf_datapath #(
		.FRAC_BITS  (FRAC_BITS),
		.ATAN_STEPS (ATAN_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.status    (status)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a word while busy");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.op == imucf_pkg::CMD_EMIT && m_tvalid && !m_tready))
		else $error("result overwritten");
	a_div_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.op == imucf_pkg::CMD_DIV_STEP && status.div_done))
		else $error("divider stepped past end");
`endif

endmodule
`default_nettype wire

>>> design/imucf_ctrl.sv
// Sequencer of the filter: issues datapath commands for one sample at a time.
`default_nettype none
module imucf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire imucf_pkg::status_t status,
	output imucf_pkg::cmd_t        cmd
);

	imucf_pkg::state_t state_q, state_d;
	logic axis_q, axis_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imucf_pkg::ST_IDLE;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		s_tready = 1'b0;
		cmd.op   = imucf_pkg::CMD_NONE;
		cmd.axis = axis_q;
		case (state_q)
			imucf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = imucf_pkg::CMD_LOAD;
					axis_d  = 1'b0;
					state_d = imucf_pkg::ST_DIV_INIT;
				end
			end
			imucf_pkg::ST_DIV_INIT: begin
				cmd.op  = imucf_pkg::CMD_DIV_INIT;
				state_d = imucf_pkg::ST_DIV;
			end
			imucf_pkg::ST_DIV: begin
				if (status.div_done)
					state_d = imucf_pkg::ST_MUL_RATE;
				else
					cmd.op = imucf_pkg::CMD_DIV_STEP;
			end
			imucf_pkg::ST_MUL_RATE: begin
				cmd.op  = imucf_pkg::CMD_MUL_RATE;
				state_d = imucf_pkg::ST_INTEGRATE;
			end
			imucf_pkg::ST_INTEGRATE: begin
				cmd.op = imucf_pkg::CMD_INTEGRATE;
				if (!axis_q) begin
					axis_d  = 1'b1;
					state_d = imucf_pkg::ST_DIV_INIT;
				end else if (status.in_window) begin
					axis_d  = 1'b0;
					state_d = imucf_pkg::ST_COR_INIT;
				end else begin
					state_d = imucf_pkg::ST_IDLE;
				end
			end
			imucf_pkg::ST_COR_INIT: begin
				cmd.op  = imucf_pkg::CMD_COR_INIT;
				state_d = imucf_pkg::ST_COR;
			end
			imucf_pkg::ST_COR: begin
				if (status.cor_done)
					state_d = imucf_pkg::ST_MUL_DEG;
				else
					cmd.op = imucf_pkg::CMD_COR_STEP;
			end
			imucf_pkg::ST_MUL_DEG: begin
				cmd.op  = imucf_pkg::CMD_MUL_DEG;
				state_d = imucf_pkg::ST_MUL_KEEP;
			end
			imucf_pkg::ST_MUL_KEEP: begin
				cmd.op  = imucf_pkg::CMD_MUL_KEEP;
				state_d = imucf_pkg::ST_MUL_ACC;
			end
			imucf_pkg::ST_MUL_ACC: begin
				cmd.op  = imucf_pkg::CMD_MUL_ACC;
				state_d = imucf_pkg::ST_BLEND;
			end
			imucf_pkg::ST_BLEND: begin
				cmd.op = imucf_pkg::CMD_BLEND;
				if (!axis_q) begin
					axis_d  = 1'b1;
					state_d = imucf_pkg::ST_COR_INIT;
				end else begin
					state_d = imucf_pkg::ST_EMIT;
				end
			end
			imucf_pkg::ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.op  = imucf_pkg::CMD_EMIT;
					state_d = imucf_pkg::ST_IDLE;
				end
			end
			default: state_d = imucf_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

>>> design/imucf_datapath.sv
// Datapath: config registers, restoring divider, CORDIC, shared multiplier, angles.
`default_nettype none
module imucf_datapath #(
	parameter int FRAC_BITS  = 16,
	parameter int ATAN_STEPS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [30:0]  cfg_data,
	input  wire logic [119:0] s_tdata,
	input  wire logic         m_tready,
	output logic              m_tvalid,
	output logic [63:0]       m_tdata,
	input  wire imucf_pkg::cmd_t cmd,
	output imucf_pkg::status_t status
);

	localparam int NUM_W = imucf_pkg::IN_W + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int N_IT  = (ATAN_STEPS < imucf_pkg::MAX_ITERS) ? ATAN_STEPS
		: imucf_pkg::MAX_ITERS;
	localparam int RND_SH = 29 - FRAC_BITS;
	localparam int OUT_SH = 30 - FRAC_BITS;

	logic [30:0] win_lo_q, win_hi_q, rdiv_q, dpr_q;
	logic [16:0] kw_q, aw_q, sp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_lo_q <= 31'd1411510;
			win_hi_q <= 31'd4705028;
			kw_q     <= 17'd64225;
			aw_q     <= 17'd1310;
			rdiv_q   <= 31'd8585216;
			sp_q     <= 17'd655;
			dpr_q    <= 31'd3756840;
		end else if (cfg_we) begin
			case (cfg_index)
				imucf_pkg::REG_WINDOW_LOW:    win_lo_q <= cfg_data;
				imucf_pkg::REG_WINDOW_HIGH:   win_hi_q <= cfg_data;
				imucf_pkg::REG_KEEP_WEIGHT:   kw_q     <= cfg_data[16:0];
				imucf_pkg::REG_ACCEL_WEIGHT:  aw_q     <= cfg_data[16:0];
				imucf_pkg::REG_RATE_DIVISOR:  rdiv_q   <= cfg_data;
				imucf_pkg::REG_SAMPLE_PERIOD: sp_q     <= cfg_data[16:0];
				imucf_pkg::REG_DEG_PER_RAD:   dpr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample fields
	logic signed [23:0] ax_q, ay_q, az_q, rx_q, ry_q;
	logic               inwin_q;
	logic signed [23:0] in_ax, in_ay, in_az;
	logic [23:0]        abs_x, abs_y, abs_z;
	logic [25:0]        mag;

	assign in_ax = s_tdata[23:0];
	assign in_ay = s_tdata[47:24];
	assign in_az = s_tdata[71:48];
	assign abs_x = in_ax[23] ? 24'(-in_ax) : in_ax;
	assign abs_y = in_ay[23] ? 24'(-in_ay) : in_ay;
	assign abs_z = in_az[23] ? 24'(-in_az) : in_az;
	assign mag   = 26'(abs_x) + 26'(abs_y) + 26'(abs_z);

	always_ff @(posedge clk) begin
		if (cmd.op == imucf_pkg::CMD_LOAD) begin
			ax_q    <= in_ax;
			ay_q    <= in_ay;
			az_q    <= in_az;
			rx_q    <= s_tdata[95:72];
			ry_q    <= s_tdata[119:96];
			inwin_q <= (31'(mag) > win_lo_q) && (31'(mag) < win_hi_q);
		end
	end

	// restoring divider on magnitudes
	logic [NUM_W-1:0] num_q, quo_q;
	logic [31:0]      rem_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [23:0] rate_sel;
	logic [23:0]      rate_mag;
	logic [31:0]      rem_sh;
	logic             rem_ge;
	logic signed [NUM_W:0] quo_s;
	logic signed [31:0] q_sat;

	assign rate_sel = cmd.axis ? ry_q : rx_q;
	assign rate_mag = rate_sel[23] ? 24'(-rate_sel) : rate_sel;
	assign rem_sh   = {rem_q[30:0], num_q[NUM_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, rdiv_q};
	assign quo_s    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign q_sat    = (rdiv_q == '0) ? '0
		: imucf_pkg::sat32(imucf_pkg::SAT_W'(quo_s));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.op == imucf_pkg::CMD_DIV_INIT)
			cnt_q <= CNT_W'(NUM_W);
		else if (cmd.op == imucf_pkg::CMD_DIV_STEP)
			cnt_q <= cnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == imucf_pkg::CMD_DIV_INIT) begin
			num_q <= {rate_mag, {FRAC_BITS{1'b0}}};
			quo_q <= '0;
			rem_q <= '0;
			neg_q <= rate_sel[23];
		end else if (cmd.op == imucf_pkg::CMD_DIV_STEP) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_sh - {1'b0, rdiv_q} : rem_sh;
		end
	end

	// CORDIC vectoring
	logic signed [imucf_pkg::CXY_W-1:0] cx_q, cy_q, xs0, ys0, xsh, ysh;
	logic signed [imucf_pkg::CZ_W-1:0]  cz_q, ang_r;
	logic [4:0] it_q;
	logic       zero_q;
	logic signed [23:0] cy_in;

	assign cy_in = cmd.axis ? ax_q : ay_q;
	assign xs0   = imucf_pkg::CXY_W'(az_q) <<< 16;
	assign ys0   = imucf_pkg::CXY_W'(cy_in) <<< 16;
	assign xsh   = cx_q >>> it_q;
	assign ysh   = cy_q >>> it_q;
	assign ang_r = zero_q ? imucf_pkg::CZ_W'(0)
		: (cz_q + imucf_pkg::CZ_W'(64'sd1 <<< RND_SH)) >>> OUT_SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			it_q <= '0;
		else if (cmd.op == imucf_pkg::CMD_COR_INIT)
			it_q <= '0;
		else if (cmd.op == imucf_pkg::CMD_COR_STEP)
			it_q <= it_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == imucf_pkg::CMD_COR_INIT) begin
			zero_q <= (az_q == '0) && (cy_in == '0);
			if (!az_q[23]) begin
				cx_q <= xs0;
				cy_q <= ys0;
				cz_q <= '0;
			end else if (!cy_in[23]) begin
				cx_q <= ys0;
				cy_q <= -xs0;
				cz_q <= imucf_pkg::HALF_PI_Q30;
			end else begin
				cx_q <= -ys0;
				cy_q <= xs0;
				cz_q <= -imucf_pkg::HALF_PI_Q30;
			end
		end else if (cmd.op == imucf_pkg::CMD_COR_STEP) begin
			if (!cy_q[imucf_pkg::CXY_W-1]) begin
				cx_q <= cx_q + ysh;
				cy_q <= cy_q - xsh;
				cz_q <= cz_q + imucf_pkg::atan_q30(it_q);
			end else begin
				cx_q <= cx_q - ysh;
				cy_q <= cy_q + xsh;
				cz_q <= cz_q - imucf_pkg::atan_q30(it_q);
			end
		end
	end

	// shared multiplier and angle state
	logic signed [imucf_pkg::MA_W-1:0]   mul_a, deg_q;
	logic signed [imucf_pkg::MB_W-1:0]   mul_b;
	logic signed [imucf_pkg::PROD_W-1:0] prod_q, prod_sh, p1_q;
	logic signed [31:0] pitch_q, roll_q, ang_sel;
	logic signed [imucf_pkg::SAT_W-1:0] int_sum, blend_sum;

	assign ang_sel = cmd.axis ? roll_q : pitch_q;
	assign prod_sh = prod_q >>> FRAC_BITS;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			imucf_pkg::CMD_MUL_RATE: begin
				mul_a = imucf_pkg::MA_W'(q_sat);
				mul_b = $signed({16'd0, sp_q});
			end
			imucf_pkg::CMD_MUL_DEG: begin
				mul_a = ang_r;
				mul_b = $signed({2'd0, dpr_q});
			end
			imucf_pkg::CMD_MUL_KEEP: begin
				mul_a = imucf_pkg::MA_W'(ang_sel);
				mul_b = $signed({16'd0, kw_q});
			end
			imucf_pkg::CMD_MUL_ACC: begin
				mul_a = deg_q;
				mul_b = $signed({16'd0, aw_q});
			end
			default: ;
		endcase
	end

	assign int_sum = cmd.axis
		? imucf_pkg::SAT_W'(roll_q) - imucf_pkg::SAT_W'(prod_sh)
		: imucf_pkg::SAT_W'(pitch_q) + imucf_pkg::SAT_W'(prod_sh);
	assign blend_sum = imucf_pkg::SAT_W'(p1_q) + imucf_pkg::SAT_W'(prod_sh);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.op == imucf_pkg::CMD_MUL_KEEP)
			deg_q <= prod_sh[imucf_pkg::MA_W-1:0];
		if (cmd.op == imucf_pkg::CMD_MUL_ACC)
			p1_q <= prod_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= '0;
			roll_q  <= '0;
		end else if (cmd.op == imucf_pkg::CMD_INTEGRATE) begin
			if (cmd.axis)
				roll_q <= imucf_pkg::sat32(int_sum);
			else
				pitch_q <= imucf_pkg::sat32(int_sum);
		end else if (cmd.op == imucf_pkg::CMD_BLEND) begin
			if (cmd.axis)
				roll_q <= imucf_pkg::sat32(blend_sum);
			else
				pitch_q <= imucf_pkg::sat32(blend_sum);
		end
	end

	// output register
	logic        ovalid_q;
	logic [63:0] odata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (cmd.op == imucf_pkg::CMD_EMIT)
			ovalid_q <= 1'b1;
		else if (m_tready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == imucf_pkg::CMD_EMIT)
			odata_q <= {roll_q, pitch_q};
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;

	assign status.div_done  = (cnt_q == '0);
	assign status.cor_done  = (it_q == 5'(N_IT));
	assign status.in_window = inwin_q;
	assign status.out_busy  = ovalid_q && !m_tready;

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Testbench for the IMU complementary filter: directed table, random samples, random stalls.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

	localparam int FRAC     = 16;
	localparam int CORDIC_N = 16;
	localparam int DRAIN    = 200;
	localparam int WD_LIMIT = 4000;
	localparam longint AMAX = 8388607;

	typedef struct packed {
		logic [31:0] pitch;
		logic [31:0] roll;
	} angles_t;

	typedef struct {
		longint ax, ay, az, rx, ry;
		bit     typed;   // expected outcome typed in: no result
	} sample_row_t;

	logic         clk, arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [30:0]  cfg_data;
	logic         s_tvalid, s_tready;
	logic [119:0] s_tdata;
	logic         m_tvalid, m_tready;
	logic [63:0]  m_tdata;

	imu_complementary_filter_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	angles_t angle_q[$];
	int      errors = 0;
	int      idle_cycles = 0;
	bit      no_idle = 0;
	longint  win_lo, win_hi, w_keep, w_acc, r_div, t_step, k_deg;
	longint  pitch_st, roll_st;

	const longint ATAN_TAB[24] = '{
		843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388438, 4194284, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
		1024, 512, 256, 128};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fxmul(longint a, longint b);
		return (a * b) >>> FRAC;
	endfunction

	function automatic longint vec_angle(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		x = x * 65536;
		y = y * 65536;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 64'sd1686629713;
			end else begin
				x = -y; y = t; z = -64'sd1686629713;
			end
		end
		for (int i = 0; i < CORDIC_N && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += ATAN_TAB[i];
			end else begin
				x = x - ys; y = y + xs; z -= ATAN_TAB[i];
			end
		end
		return (z + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
	endfunction

	function automatic longint gyro_step(longint rate);
		longint q;
		q = 0;
		if (r_div != 0) q = clamp32((rate * 65536) / r_div);
		return fxmul(q, t_step);
	endfunction

	function automatic longint fuse(longint ang, longint y, longint x);
		longint deg;
		deg = fxmul(vec_angle(y, x), k_deg);
		return clamp32(fxmul(ang, w_keep) + fxmul(deg, w_acc));
	endfunction

	function automatic bit filter_step(longint ax, ay, az, rx, ry, output angles_t res);
		longint mag;
		pitch_st = clamp32(pitch_st + gyro_step(rx));
		roll_st  = clamp32(roll_st - gyro_step(ry));
		mag = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
		res = '0;
		if (!(mag > win_lo && mag < win_hi)) return 0;
		pitch_st = fuse(pitch_st, ay, az);
		roll_st  = fuse(roll_st, ax, az);
		res.pitch = pitch_st[31:0];
		res.roll  = roll_st[31:0];
		return 1;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result side: random stalls, compare words
	int stall = 0;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (angle_q.size() == 0)
				report("unexpected word", m_tdata[31:0], '0);
			else begin
				angles_t e;
				e = angle_q.pop_front();
				if (m_tdata[31:0] !== e.pitch) report("pitch", m_tdata[31:0], e.pitch);
				if (m_tdata[63:32] !== e.roll) report("roll", m_tdata[63:32], e.roll);
			end
			stall = no_idle ? 0 : $urandom_range(0, 18);
		end
		if (stall > 0) begin
			stall--;
			m_tready <= 0;
		end else
			m_tready <= 1;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WD_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, longint v);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= v[30:0];
		@(posedge clk);
		case (idx)
			imucf_pkg::REG_WINDOW_LOW:    win_lo = v & 64'h7FFFFFFF;
			imucf_pkg::REG_WINDOW_HIGH:   win_hi = v & 64'h7FFFFFFF;
			imucf_pkg::REG_KEEP_WEIGHT:   w_keep = v & 64'h1FFFF;
			imucf_pkg::REG_ACCEL_WEIGHT:  w_acc  = v & 64'h1FFFF;
			imucf_pkg::REG_RATE_DIVISOR:  r_div  = v & 64'h7FFFFFFF;
			imucf_pkg::REG_SAMPLE_PERIOD: t_step = v & 64'h1FFFF;
			imucf_pkg::REG_DEG_PER_RAD:   k_deg  = v & 64'h7FFFFFFF;
			default: ;
		endcase
	endtask

	task automatic set_filter(longint lo, hi, kw, aw, dv, sp, dg);
		while (angle_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		write_reg(imucf_pkg::REG_WINDOW_LOW, lo);
		write_reg(imucf_pkg::REG_WINDOW_HIGH, hi);
		write_reg(imucf_pkg::REG_KEEP_WEIGHT, kw);
		write_reg(imucf_pkg::REG_ACCEL_WEIGHT, aw);
		write_reg(imucf_pkg::REG_RATE_DIVISOR, dv);
		write_reg(imucf_pkg::REG_SAMPLE_PERIOD, sp);
		write_reg(imucf_pkg::REG_DEG_PER_RAD, dg);
		cfg_we <= 0;
	endtask

	task automatic send_sample(longint ax, ay, az, rx, ry, bit typed);
		int gap;
		angles_t res;
		bit has;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {ry[23:0], rx[23:0], az[23:0], ay[23:0], ax[23:0]};
		do @(posedge clk); while (!s_tready);
		has = filter_step(ax, ay, az, rx, ry, res);
		if (typed) begin
			if (has) report("typed row predicts no word", 32'd1, 32'd0);
		end else if (has)
			angle_q.push_back(res);
	endtask

	function automatic longint rnd_signed();
		longint v;
		v = $urandom() & 32'hFFFFFF;
		return v >= 64'h800000 ? v - 64'h1000000 : v;
	endfunction

	function automatic longint signed_of(longint v);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	task automatic random_sample();
		longint m, a, b, c, rx, ry, lo, top;
		rx = $urandom_range(0, 3) == 0 ? rnd_signed() : signed_of($urandom_range(0, 65536 * 120));
		ry = $urandom_range(0, 3) == 0 ? rnd_signed() : signed_of($urandom_range(0, 65536 * 120));
		top = win_hi - 1 < 3 * AMAX ? win_hi - 1 : 3 * AMAX;
		if ($urandom_range(0, 9) < 7 && win_lo + 1 <= top) begin
			m = win_lo + 1 + longint'($urandom_range(0, 32'hFFFFFFFF)) % (top - win_lo);
			lo = m - 2 * AMAX > 0 ? m - 2 * AMAX : 0;
			a = lo + longint'($urandom()) % ((m < AMAX ? m : AMAX) - lo + 1);
			lo = m - a - AMAX > 0 ? m - a - AMAX : 0;
			b = lo + longint'($urandom()) % (((m - a) < AMAX ? m - a : AMAX) - lo + 1);
			c = m - a - b;
			send_sample(signed_of(a), signed_of(b), signed_of(c), rx, ry, 0);
		end else
			send_sample(rnd_signed(), rnd_signed(), rnd_signed(), rx, ry, 0);
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			no_idle = (i < n / 5);
			random_sample();
		end
		no_idle = 0;
		s_tvalid <= 0;
	endtask

	sample_row_t rows[] = '{
		'{0, 0, 0, 0, 0, 1},
		'{-8388608, -8388608, -8388608, 0, 0, 1},
		'{1411510, 0, 0, 0, 0, 1},
		'{0, 4705028, 0, 0, 0, 1},
		'{0, 0, 1411511, 0, 0, 0},
		'{0, 0, 4705027, 0, 0, 0},
		'{0, 0, 2621440, 0, 0, 0},
		'{0, 65536, -2621440, 0, 0, 0},
		'{65536, -65536, -2621440, 0, 0, 0},
		'{-2621440, 0, -65536, 8388607, -8388608, 0},
		'{2000000, 1000000, 0, -8388608, 8388607, 0},
		'{-1000000, -2000000, 500000, 8388607, 8388607, 0},
		'{8388607, 0, 0, 0, 0, 1},
		'{1500000, 1500000, 1500000, -8388608, -8388608, 0},
		'{0, 0, -2621440, 1234567, -7654321, 0},
		'{-3000000, 0, 0, 0, 0, 0}
	};

	initial begin
		arst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
		s_tvalid = 0; s_tdata = '0; m_tready = 0;
		win_lo = 1411510; win_hi = 4705028; w_keep = 64225; w_acc = 1310;
		r_div = 8585216; t_step = 655; k_deg = 3756840;
		pitch_st = 0; roll_st = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i])
			send_sample(rows[i].ax, rows[i].ay, rows[i].az, rows[i].rx, rows[i].ry,
				rows[i].typed);
		random_phase(220);
		set_filter(0, 2147483647, 65536, 65536, 1, 65536, 2147483647);
		random_phase(150);
		set_filter(100, 200, 0, 0, 0, 1, 0);
		random_phase(150);
		set_filter(2147483647, 2147483647, 65536, 0, 2147483647, 65536, 0);
		random_phase(40);
		set_filter(0, 0, 0, 65536, 65536, 1, 3756840);
		random_phase(40);
		set_filter($urandom_range(0, 3000000), $urandom_range(6000000, 30000000),
			$urandom_range(0, 65536), $urandom_range(0, 65536),
			$urandom_range(65536, 32'h7FFFFFFF), $urandom_range(1, 65536),
			$urandom_range(0, 32'h7FFFFFFF));
		random_phase(300);
		set_filter(1411510, 4705028, 64225, 1310, 8585216, 655, 3756840);
		random_phase(300);
		while (angle_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
